>>> rtl/kdch_pkg.sv
// Package for the key debounce / click / hold unit.
// Field widths, flag bit positions, register indexes and reset values.
// No dependencies; compiled first.
`default_nettype none

package kdch_pkg;

  // Keys carried by the item fields
  localparam int FIELD_KEYS   = 3;
  localparam int NUM_KEYS_DEF = 3;
  localparam int FLAG_W       = 6;
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  // Sticky flag bit positions (bit 3 is unused and stays clear)
  localparam int FLAG_HOLD   = 0;
  localparam int FLAG_CLICK  = 1;
  localparam int FLAG_DOUBLE = 2;
  localparam int FLAG_RISE   = 4;
  localparam int FLAG_FALL   = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULL_DOWN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT      = 2'd3;

  // Register reset values
  localparam logic [FIELD_KEYS-1:0] PULL_DOWN_RST = 3'd0;
  localparam logic [CNT_W-1:0]      DEBOUNCE_RST  = 8'd5;
  localparam logic [CNT_W-1:0]      HOLD_RST      = 8'd150;
  localparam logic [CNT_W-1:0]      WAIT_RST      = 8'd100;

  localparam logic [CNT_W-1:0]      CNT_MAX       = 8'd255;

endpackage : kdch_pkg

`default_nettype wire

>>> rtl/kdch_if.sv
// Valid/ready channel interfaces for the key debounce / click / hold unit.
// Depends on kdch_pkg for the field widths.
`default_nettype none

interface kdch_in_if import kdch_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_KEYS-1:0] raw_levels;
  logic [FIELD_KEYS-1:0] clear_request;

  modport source (output valid, output raw_levels, output clear_request, input ready);
  modport sink   (input valid, input raw_levels, input clear_request, output ready);
endinterface : kdch_in_if

interface kdch_out_if import kdch_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_KEYS-1:0] stable_levels;
  logic [FLAG_W-1:0]     flags_key0;
  logic [FLAG_W-1:0]     flags_key1;
  logic [FLAG_W-1:0]     flags_key2;

  modport source (output valid, output stable_levels, output flags_key0,
                  output flags_key1, output flags_key2, input ready);
  modport sink   (input valid, input stable_levels, input flags_key0,
                  input flags_key1, input flags_key2, output ready);
endinterface : kdch_out_if

`default_nettype wire

>>> rtl/key_debounce_click_hold_unit.sv
// Top level of the key debounce / click / hold unit: per-key state machines.
// Depends on kdch_pkg and the channel interfaces in kdch_if.sv.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    raw_levels[2:0], clear_request[2:0]
//   out_ch   out  valid/ready    stable_levels[2:0], flags_key0..2[5:0]
//   cfg_*    in   cfg_we only    cfg_index[1:0], cfg_data[7:0]
//
// One transaction per cycle unless out_ch stalls; results are registered.
// The key state registers are the result register: they update only when a
// transaction is accepted, so a stalled result holds by itself.
// in_ch.ready is high while the result register is empty or being drained.
// Reset (synchronous, rst_n low) puts every key idle at the released level
// and loads the register reset values.
`default_nettype none

module key_debounce_click_hold_unit
  import kdch_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  kdch_in_if.sink                    in_ch,
  kdch_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAD_W = (NUM_KEYS > FIELD_KEYS) ? NUM_KEYS : FIELD_KEYS;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_PRESSED,
    PH_CLICK
  } phase_t;

  // Configuration registers
  logic [FIELD_KEYS-1:0] pull_down_r;
  logic [CNT_W-1:0]      debounce_r;
  logic [CNT_W-1:0]      hold_r;
  logic [CNT_W-1:0]      wait_r;

  // Per-key state
  phase_t              phase_r   [NUM_KEYS];
  phase_t              phase_nxt [NUM_KEYS];
  logic [NUM_KEYS-1:0] stable_r;
  logic [NUM_KEYS-1:0] stable_nxt;
  logic [CNT_W-1:0]    press_r   [NUM_KEYS];
  logic [CNT_W-1:0]    press_nxt [NUM_KEYS];
  logic [CNT_W-1:0]    gap_r     [NUM_KEYS];
  logic [CNT_W-1:0]    gap_nxt   [NUM_KEYS];
  logic [FLAG_W-1:0]   flags_r   [NUM_KEYS];
  logic [FLAG_W-1:0]   flags_nxt [NUM_KEYS];

  logic                out_valid_r;
  logic                in_accept;

  // Keys beyond the field width read level 0, are never cleared, pull up
  logic [PAD_W-1:0]    raw_pad;
  logic [PAD_W-1:0]    clr_pad;
  logic [PAD_W-1:0]    pd_pad;
  logic [PAD_W-1:0]    pd_rst_pad;
  logic [PAD_W-1:0]    stable_pad;
  logic [FLAG_W-1:0]   flags_pad [PAD_W];

  assign raw_pad    = PAD_W'(in_ch.raw_levels);
  assign clr_pad    = PAD_W'(in_ch.clear_request);
  assign pd_pad     = PAD_W'(pull_down_r);
  assign pd_rst_pad = PAD_W'(PULL_DOWN_RST);

  // Take a new transaction while the result register is empty or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Next state of every key for the incoming transaction
  always_comb begin
    logic              raw;
    logic [FLAG_W-1:0] flg;
    logic [CNT_W-1:0]  gap;
    logic [CNT_W-1:0]  cnt;
    for (int k = 0; k < NUM_KEYS; k++) begin
      raw           = raw_pad[k];
      flg           = clr_pad[k] ? '0 : flags_r[k];
      gap           = (gap_r[k] < wait_r) ? CNT_W'(gap_r[k] + 1'b1) : gap_r[k];
      cnt           = press_r[k];
      phase_nxt[k]  = phase_r[k];
      stable_nxt[k] = stable_r[k];
      unique case (phase_r[k])
        PH_IDLE: begin
          if (stable_r[k] != raw) begin
            cnt          = '0;
            phase_nxt[k] = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          cnt = (stable_r[k] == raw) ? '0 : CNT_W'(press_r[k] + 1'b1);
          if (cnt >= debounce_r) begin
            if (raw) flg[FLAG_RISE] = 1'b1;
            else     flg[FLAG_FALL] = 1'b1;
            stable_nxt[k] = raw;
            phase_nxt[k]  = (raw == pd_pad[k]) ? PH_PRESSED : PH_CLICK;
            cnt           = '0;
          end
        end
        PH_PRESSED: begin
          if (raw != stable_r[k]) begin
            phase_nxt[k] = PH_DEBOUNCE;
            cnt          = '0;
          end
          if (cnt > hold_r) flg[FLAG_HOLD] = 1'b1;
          else if (cnt != CNT_MAX) cnt = CNT_W'(cnt + 1'b1);
        end
        PH_CLICK: begin
          flg[FLAG_CLICK] = 1'b1;
          if (gap < wait_r) flg[FLAG_DOUBLE] = 1'b1;
          gap          = '0;
          phase_nxt[k] = PH_IDLE;
        end
      endcase
      press_nxt[k] = cnt;
      gap_nxt[k]   = gap;
      flags_nxt[k] = flg;
    end
  end

  // Hold configuration, key state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pull_down_r <= PULL_DOWN_RST;
      debounce_r  <= DEBOUNCE_RST;
      hold_r      <= HOLD_RST;
      wait_r      <= WAIT_RST;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_r[k]  <= PH_IDLE;
        stable_r[k] <= ~pd_rst_pad[k];
        press_r[k]  <= '0;
        gap_r[k]    <= '0;
        flags_r[k]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PULL_DOWN: pull_down_r <= cfg_data[FIELD_KEYS-1:0];
          CFG_DEBOUNCE:  debounce_r  <= cfg_data;
          CFG_HOLD:      hold_r      <= cfg_data;
          CFG_WAIT:      wait_r      <= cfg_data;
        endcase
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
        stable_r    <= stable_nxt;
        for (int k = 0; k < NUM_KEYS; k++) begin
          phase_r[k] <= phase_nxt[k];
          press_r[k] <= press_nxt[k];
          gap_r[k]   <= gap_nxt[k];
          flags_r[k] <= flags_nxt[k];
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Report only the keys the fields carry; absent keys read as zero
  always_comb begin
    stable_pad = '0;
    for (int k = 0; k < PAD_W; k++) begin
      flags_pad[k] = '0;
    end
    for (int k = 0; k < NUM_KEYS; k++) begin
      stable_pad[k] = stable_r[k];
      flags_pad[k]  = flags_r[k];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.stable_levels = stable_pad[FIELD_KEYS-1:0];
  assign out_ch.flags_key0    = flags_pad[0];
  assign out_ch.flags_key1    = flags_pad[1];
  assign out_ch.flags_key2    = flags_pad[2];

  // Every accepted transaction leaves a result waiting
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_ch.valid)
    else $error("no result after an accepted transaction");

  // Debounced levels move only with an accepted transaction
  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(stable_r))
    else $error("stable levels changed without a transaction");

  // Key 0's click check lasts a single transaction
  a_click_once: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r[0] == PH_CLICK) |=> (phase_r[0] == PH_IDLE))
    else $error("key 0 stayed in click check");

  // The unused flag bit never sets on key 0
  a_flag_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (flags_r[0][3] == 1'b0))
    else $error("unused flag bit set on key 0");

endmodule : key_debounce_click_hold_unit

`default_nettype wire

>>> dv/tb_key_debounce_click_hold_unit.sv
// Testbench for key_debounce_click_hold_unit: random key-press traffic checked against
// a per-key debounce / click / hold predictor. Needs kdch_pkg, kdch_if.sv and the RTL top.
`timescale 1ns / 100ps

module tb_key_debounce_click_hold_unit;
  import kdch_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_OFF_LEN = 64;
  localparam int SHOW_MAX     = 10;

  typedef enum logic [1:0] {
    KP_REST, KP_SETTLE, KP_HELD, KP_RELEASED
  } key_phase_t;

  typedef struct packed {
    logic [FIELD_KEYS-1:0] raw;
    logic [FIELD_KEYS-1:0] clr;
  } key_sample_t;

  localparam int SAMPLE_W = $bits(key_sample_t);

  typedef struct packed {
    logic [FIELD_KEYS-1:0] levels;
    logic [FLAG_W-1:0]     flags0;
    logic [FLAG_W-1:0]     flags1;
    logic [FLAG_W-1:0]     flags2;
  } key_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kdch_in_if  in_ch ();
  kdch_out_if out_ch ();

  key_debounce_click_hold_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers and of each key's state
  logic [FIELD_KEYS-1:0] pd_mask;
  logic [CNT_W-1:0]      deb_ticks, hold_ticks, wait_ticks;
  key_phase_t            key_phase [FIELD_KEYS];
  logic                  key_level [FIELD_KEYS];
  logic [CNT_W-1:0]      press_cnt [FIELD_KEYS];
  logic [CNT_W-1:0]      gap_cnt   [FIELD_KEYS];
  logic [FLAG_W-1:0]     key_flags [FIELD_KEYS];

  key_sample_t samples_pending [$];
  key_report_t reports_due [$];

  // Stimulus shaping: intended level and remaining run length per key
  logic drive_level [FIELD_KEYS];
  int   run_left    [FIELD_KEYS];

  logic in_took;
  logic quiet;
  bit   calm;
  bit   hold_off_req;
  int   send_gap, ready_gap, hold_off_left, stall_cycles;
  int   errors, samples_sent, reports_checked, settings_used;
  logic [FLAG_W-1:0] flags_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_keys();
    int k;
    pd_mask    = PULL_DOWN_RST;
    deb_ticks  = DEBOUNCE_RST;
    hold_ticks = HOLD_RST;
    wait_ticks = WAIT_RST;
    for (k = 0; k < FIELD_KEYS; k++) begin
      key_phase[k] = KP_REST;
      key_level[k] = ~pd_mask[k];
      press_cnt[k] = '0;
      gap_cnt[k]   = '0;
      key_flags[k] = '0;
      drive_level[k] = key_level[k];
      run_left[k]    = 0;
    end
  endfunction

  // Advance every key by one tick and return the report it produces
  function automatic key_report_t debounce_tick(input logic [FIELD_KEYS-1:0] raw,
                                                input logic [FIELD_KEYS-1:0] clr);
    key_report_t rep;
    int k;
    for (k = 0; k < FIELD_KEYS; k++) begin
      if (clr[k]) key_flags[k] = '0;
      if (gap_cnt[k] < wait_ticks) gap_cnt[k] = gap_cnt[k] + 1'b1;
      case (key_phase[k])
        KP_REST: begin
          if (key_level[k] != raw[k]) begin
            press_cnt[k] = '0;
            key_phase[k] = KP_SETTLE;
          end
        end
        KP_SETTLE: begin
          press_cnt[k] = press_cnt[k] + 1'b1;
          if (key_level[k] == raw[k]) press_cnt[k] = '0;
          // accept the new level once it has persisted long enough
          if (press_cnt[k] >= deb_ticks) begin
            key_flags[k][raw[k] ? FLAG_RISE : FLAG_FALL] = 1'b1;
            key_level[k] = raw[k];
            key_phase[k] = (raw[k] == pd_mask[k]) ? KP_HELD : KP_RELEASED;
            press_cnt[k] = '0;
          end
        end
        KP_HELD: begin
          if (raw[k] != key_level[k]) begin
            key_phase[k] = KP_SETTLE;
            press_cnt[k] = '0;
          end
          if (press_cnt[k] > hold_ticks) key_flags[k][FLAG_HOLD] = 1'b1;
          else if (press_cnt[k] != CNT_MAX) press_cnt[k] = press_cnt[k] + 1'b1;
        end
        default: begin
          key_flags[k][FLAG_CLICK] = 1'b1;
          if (gap_cnt[k] < wait_ticks) key_flags[k][FLAG_DOUBLE] = 1'b1;
          gap_cnt[k]   = '0;
          key_phase[k] = KP_REST;
        end
      endcase
      rep.levels[k] = key_level[k];
    end
    rep.flags0 = key_flags[0];
    rep.flags1 = key_flags[1];
    rep.flags2 = key_flags[2];
    return rep;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= SHOW_MAX) $display("%t  %s", $realtime, msg);
  endfunction

  task automatic check_report(input key_report_t got);
    key_report_t want;
    if (reports_due.size() == 0) begin
      note_error($sformatf("result with nothing expected: %h", got));
      return;
    end
    want = reports_due.pop_front();
    reports_checked++;
    if (got.levels !== want.levels)
      note_error($sformatf("stable_levels exp %b got %b", want.levels, got.levels));
    if (got.flags0 !== want.flags0)
      note_error($sformatf("flags_key0 exp %b got %b", want.flags0, got.flags0));
    if (got.flags1 !== want.flags1)
      note_error($sformatf("flags_key1 exp %b got %b", want.flags1, got.flags1));
    if (got.flags2 !== want.flags2)
      note_error($sformatf("flags_key2 exp %b got %b", want.flags2, got.flags2));
  endtask

  // Monitor: check results, then predict for the accepted sample
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      quiet   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_report('{levels: out_ch.stable_levels, flags0: out_ch.flags_key0,
                       flags1: out_ch.flags_key1, flags2: out_ch.flags_key2});
        flags_seen |= out_ch.flags_key0 | out_ch.flags_key1 | out_ch.flags_key2;
      end
      if (in_ch.valid && in_ch.ready) begin
        reports_due.push_back(debounce_tick(in_ch.raw_levels, in_ch.clear_request));
        samples_sent++;
      end
      in_took <= in_ch.valid && in_ch.ready;
      quiet   <= samples_pending.size() == 0 && !in_ch.valid && reports_due.size() == 0;
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Driver: hold the offered sample until taken, idle in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_took) begin
      in_ch.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_ch.valid <= 1'b0;
    end else if (samples_pending.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
      send_gap = $urandom_range(0, 7);
      in_ch.valid <= 1'b0;
    end else if (samples_pending.size() != 0) begin
      {in_ch.raw_levels, in_ch.clear_request} <= samples_pending.pop_front();
      in_ch.valid <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result side: one long hold-off on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = HOLD_OFF_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      ready_gap = $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_PULL_DOWN: pd_mask    = val[FIELD_KEYS-1:0];
      CFG_DEBOUNCE:  deb_ticks  = val;
      CFG_HOLD:      hold_ticks = val;
      default:       wait_ticks = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [FIELD_KEYS-1:0] mask, input logic [CNT_W-1:0] deb,
                            input logic [CNT_W-1:0] hold, input logic [CNT_W-1:0] gap);
    write_reg(CFG_PULL_DOWN, {5'($urandom), mask});
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_WAIT, gap);
    settings_used++;
  endtask

  // Wait until every sample is taken and every result has come back
  task automatic drain();
    @(negedge clk);
    while (!quiet) @(negedge clk);
  endtask

  // Pick how long a key keeps one level: glitches, near the debounce,
  // hold and double-click boundaries, or just long
  function automatic int pick_run();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, int'(deb_ticks) + 1);
      1, 2:    return int'(deb_ticks) + $urandom_range(1, 3);
      3:       return int'(deb_ticks) + int'(hold_ticks) + $urandom_range(0, 8);
      4:       return int'(wait_ticks) / 2 + $urandom_range(1, 4);
      default: return int'(deb_ticks) + $urandom_range(1, 40);
    endcase
  endfunction

  task automatic queue_samples(input int n, input bit noise);
    key_sample_t s;
    int i, k;
    for (i = 0; i < n; i++) begin
      for (k = 0; k < FIELD_KEYS; k++) begin
        if (run_left[k] == 0) begin
          drive_level[k] = ~drive_level[k];
          run_left[k]    = pick_run();
        end
        run_left[k]--;
        s.raw[k] = drive_level[k] ^ ($urandom_range(0, 29) == 0);
        s.clr[k] = ($urandom_range(0, 15) == 0);
      end
      if (noise) s = key_sample_t'(SAMPLE_W'($urandom));
      samples_pending.push_back(s);
    end
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.raw_levels    = '0;
    in_ch.clear_request = '0;
    out_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    rst_n               = 1'b0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    send_gap = 0; ready_gap = 0; hold_off_left = 0; stall_cycles = 0;
    errors = 0; samples_sent = 0; reports_checked = 0; settings_used = 1;
    flags_seen = '0;
    reset_keys();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: no change, all keys pressed and released, click with double, clears
    samples_pending.push_back('{raw: 3'b111, clr: 3'b000});
    repeat (6) samples_pending.push_back('{raw: 3'b000, clr: 3'b111});
    repeat (7) samples_pending.push_back('{raw: 3'b111, clr: 3'b000});
    samples_pending.push_back('{raw: 3'b101, clr: 3'b010});
    samples_pending.push_back('{raw: 3'b010, clr: 3'b101});
    samples_pending.push_back('{raw: 3'b111, clr: 3'b111});
    drain();

    // Reset settings, so gap counters saturate at the reset wait value
    queue_samples(250, 1'b0);
    drain();

    // Lower wait below the saturated gap, flip polarity to pulled down
    set_config(3'b111, 8'd1, 8'd3, 8'd12);
    queue_samples(300, 1'b0);
    drain();

    // Zero debounce, hold and wait
    set_config(3'b101, 8'd0, 8'd0, 8'd0);
    queue_samples(150, 1'b0);
    drain();

    // Long result stall while samples keep coming
    set_config(3'b010, 8'd3, 8'd10, 8'd30);
    queue_samples(350, 1'b0);
    hold_off_req = 1'b1;
    drain();

    // Press counter saturation: hold never reached
    set_config(3'b000, 8'd1, CNT_MAX, CNT_MAX);
    queue_samples(400, 1'b0);
    drain();

    // Slowest debounce, largest hold that can still be reached, shortest nonzero wait
    set_config(3'b110, CNT_MAX, 8'd254, 8'd1);
    queue_samples(500, 1'b0);
    drain();

    // Unstructured noise with small random settings
    set_config(3'($urandom), 8'($urandom_range(0, 4)), 8'($urandom_range(0, 8)),
               8'($urandom_range(0, 16)));
    queue_samples(150, 1'b1);
    drain();

    // Final stretch at full rate on both sides
    calm = 1'b1;
    set_config(3'($urandom), 8'd2, 8'd6, 8'd20);
    queue_samples(150, 1'b0);
    drain();
    repeat (4) @(negedge clk);

    if (reports_due.size() != 0)
      note_error($sformatf("%0d results never arrived", reports_due.size()));
    $display("%0d samples, %0d results checked over %0d register settings",
             samples_sent, reports_checked, settings_used);
    $display("flag bits seen set: %b, mismatches: %0d", flags_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : tb_key_debounce_click_hold_unit
